FILE: design/jpoe_pkg.sv
// Shared types, codes and constants for the JSON payload object extractor.
// No dependencies; compiled first.
package jpoe_pkg;

  // Character counter width; valid range 8 to 32.
  localparam int CountWidth = 16;
  localparam int LenWidth   = 16;
  localparam int CmpWidth   = (CountWidth > LenWidth) ? CountWidth : LenWidth;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [LenWidth-1:0]   LenMax   = {LenWidth{1'b1}};
  localparam logic [15:0]           DepthMax = 16'hFFFF;

  localparam logic [15:0] BufferSizeReset = 16'd1024;

  localparam int          KeyLen  = 10;
  localparam logic [3:0]  KeyLast = 4'(KeyLen - 1);

  localparam logic [7:0] BraceOpen  = 8'h7B;  // '{'
  localparam logic [7:0] BraceClose = 8'h7D;  // '}'

  typedef enum logic [2:0] {
    PhSearch = 3'd0,
    PhSeek   = 3'd1,
    PhObject = 3'd2,
    PhDone   = 3'd3
  } phase_t;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoKey    = 3'd1,
    StNoBrace  = 3'd2,
    StNoEnd    = 3'd3,
    StTooLarge = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                status_valid;
    status_t             status;
    logic [LenWidth-1:0] payload_length;
  } result_t;

  // Key text: "payload":
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h22;  // "
      4'd1:    ch = 8'h70;  // p
      4'd2:    ch = 8'h61;  // a
      4'd3:    ch = 8'h79;  // y
      4'd4:    ch = 8'h6C;  // l
      4'd5:    ch = 8'h6F;  // o
      4'd6:    ch = 8'h61;  // a
      4'd7:    ch = 8'h64;  // d
      4'd8:    ch = 8'h22;  // "
      4'd9:    ch = 8'h3A;  // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Count reported as payload_length, saturating.
  function automatic logic [LenWidth-1:0] len_of(input logic [CountWidth-1:0] cnt);
    logic [CmpWidth-1:0] wide;
    wide = CmpWidth'(cnt);
    if (wide > CmpWidth'(LenMax)) begin
      return LenMax;
    end
    return wide[LenWidth-1:0];
  endfunction

endpackage

FILE: design/jpoe_if.sv
// Channel interfaces of the JSON payload object extractor: input, result, config.
// Independent of the package; valid/ready handshake on each.
interface jpoe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       msg_last;
  modport source (output valid, output in_byte, output msg_last, input ready);
  modport sink   (input valid, input in_byte, input msg_last, output ready);
endinterface

interface jpoe_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        status_valid;
  logic [2:0]  status;
  logic [15:0] payload_length;
  modport source (output valid, output out_byte, output byte_valid, output status_valid,
                  output status, output payload_length, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input status_valid,
                  input status, input payload_length, output ready);
endinterface

interface jpoe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] buffer_size;
  modport source (output valid, output buffer_size, input ready);
  modport sink   (input valid, input buffer_size, output ready);
endinterface

FILE: design/json_payload_object_extractor.sv
// Top level of the JSON payload object extractor.
// Depends on jpoe_pkg and the channel interfaces in jpoe_if.sv.

// Streams a message one character per word, finds the first "payload": key,
// then passes through the object that follows, from its '{' to the matching
// '}' (braces counted without regard to quoting), and reports one status per
// message: ok or too_large on the closing brace, or key / brace / end not
// found on the last character. Rate: one character per clock cycle while out_ch
// keeps up. All per-character work (key matcher with fallback, brace depth,
// length count) is one pass of logic into a result register; a one-word skid
// register behind it keeps in_ch.ready high through an out_ch stall until the
// skid fills, so ready only drops after the downstream side has held off two
// results. Characters that produce neither payload nor status yield no result
// word. The user must write buffer_size via cfg_ch only while the block is
// idle; the block itself does not enforce this. cfg_ch.ready is always high.
module json_payload_object_extractor (
  input  logic              clk,
  input  logic              rst_n,
  jpoe_in_if.sink           in_ch,
  jpoe_out_if.source        out_ch,
  jpoe_cfg_if.sink          cfg_ch
);
  import jpoe_pkg::*;

  // Scan state
  phase_t                phase_r, phase_nxt;
  logic [3:0]            match_r, match_nxt;
  logic [15:0]           depth_r, depth_nxt;
  logic [CountWidth-1:0] count_r, count_nxt;
  logic [15:0]           buf_size_r;

  // Output register and skid
  result_t main_r, skid_r;
  logic    main_valid_r, skid_valid_r;

  logic       in_fire, pop;
  logic [7:0] c;
  logic       last;
  phase_t     phase_cur, phase_step;
  logic [3:0] j0, j_step;
  logic       key_done;
  logic [15:0]           depth_dec;
  logic [CountWidth-1:0] count_inc;
  logic                  close_hit;
  logic                  too_large;
  result_t               res;
  logic                  has_res;

  assign c       = in_ch.in_byte;
  assign last    = in_ch.msg_last;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !skid_valid_r;
  assign cfg_ch.ready = 1'b1;

  // Unused phase codes fall back to searching
  always_comb begin
    case (phase_r)
      PhSearch, PhSeek, PhObject, PhDone: phase_cur = phase_r;
      default:                            phase_cur = PhSearch;
    endcase
  end

  // Key matcher; only position 9 has a nonzero fallback (to 1, past the quote)
  assign j0 = (match_r > KeyLast) ? 4'd0 : match_r;
  always_comb begin
    if (c == key_char(j0)) begin
      j_step = j0 + 4'd1;
    end else if (j0 == KeyLast && c == key_char(4'd1)) begin
      j_step = 4'd2;
    end else if (c == key_char(4'd0)) begin
      j_step = 4'd1;
    end else begin
      j_step = 4'd0;
    end
  end
  assign key_done = (j_step == 4'(KeyLen));

  assign depth_dec = (depth_r != 16'd0) ? depth_r - 16'd1 : 16'd0;
  assign count_inc = (count_r != CountMax) ? count_r + CountWidth'(1) : count_r;
  assign close_hit = (c == BraceClose) && (depth_dec == 16'd0);
  assign too_large = (CmpWidth'(count_inc) >= CmpWidth'(buf_size_r)) ||
                     (count_inc == CountMax);

  // Next phase
  always_comb begin
    phase_step = phase_cur;
    case (phase_cur)
      PhSearch: if (key_done) begin
        phase_step = PhSeek;
      end
      PhSeek: if (c == BraceOpen) begin
        phase_step = PhObject;
      end
      PhObject: if (close_hit) begin
        phase_step = PhDone;
      end
      PhDone:   phase_step = PhDone;
      default:  phase_step = PhSearch;
    endcase
    phase_nxt = last ? PhSearch : phase_step;
  end

  // Datapath and result word
  always_comb begin
    match_nxt = match_r;
    depth_nxt = depth_r;
    count_nxt = count_r;
    res       = '0;
    case (phase_cur)
      PhSearch: begin
        match_nxt = key_done ? 4'd0 : j_step;
      end
      PhSeek: if (c == BraceOpen) begin
        depth_nxt      = 16'd1;
        count_nxt      = CountWidth'(1);
        res.byte_valid = 1'b1;
      end
      PhObject: begin
        res.byte_valid = 1'b1;
        count_nxt      = count_inc;
        if (c == BraceOpen) begin
          depth_nxt = (depth_r != DepthMax) ? depth_r + 16'd1 : depth_r;
        end else if (c == BraceClose) begin
          depth_nxt = depth_dec;
          if (close_hit) begin
            res.status_valid   = 1'b1;
            res.status         = too_large ? StTooLarge : StOk;
            res.payload_length = len_of(count_inc);
          end
        end
      end
      default: ;
    endcase
    if (res.byte_valid) begin
      res.out_byte = c;
    end
    if (last) begin
      if (!res.status_valid && phase_step != PhDone) begin
        res.status_valid = 1'b1;
        case (phase_step)
          PhSearch: res.status = StNoKey;
          PhSeek:   res.status = StNoBrace;
          default: begin
            res.status         = StNoEnd;
            res.payload_length = len_of(count_nxt);
          end
        endcase
      end
      match_nxt = 4'd0;
      depth_nxt = 16'd0;
      count_nxt = '0;
    end
  end
  assign has_res = res.byte_valid || res.status_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PhSearch;
      match_r    <= 4'd0;
      depth_r    <= 16'd0;
      count_r    <= '0;
      buf_size_r <= BufferSizeReset;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        match_r <= match_nxt;
        depth_r <= depth_nxt;
        count_r <= count_nxt;
      end
      if (cfg_ch.valid) begin
        buf_size_r <= cfg_ch.buffer_size;
      end
    end
  end

  // Output register with one-word skid
  assign pop = main_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= in_fire && has_res;
      end
    end else if (in_fire && has_res) begin
      if (!main_valid_r) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_r <= skid_valid_r ? skid_r : res;
    end else if (!main_valid_r) begin
      main_r <= res;
    end
    if (!skid_valid_r) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid          = main_valid_r;
  assign out_ch.out_byte       = main_r.out_byte;
  assign out_ch.byte_valid     = main_r.byte_valid;
  assign out_ch.status_valid   = main_r.status_valid;
  assign out_ch.status         = main_r.status;
  assign out_ch.payload_length = main_r.payload_length;

`ifndef ASSERT_OFF
  // Skid only fills behind an occupied main register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held without main word");

  // Inside the object the depth never sits at zero
  a_depth_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PhObject) |-> (depth_r != 16'd0))
    else $error("object phase with zero brace depth");

  // Last character of a message restarts the scan
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last) |=> (phase_r == PhSearch && count_r == '0 && match_r == 4'd0))
    else $error("scan state not cleared at message end");

  // Every delivered word carries payload or status
  a_word_content: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r |-> (main_r.byte_valid || main_r.status_valid))
    else $error("empty result word");
`endif

endmodule

FILE: tb/tb_json_payload_object_extractor.sv
// Self-checking testbench for json_payload_object_extractor: directed, boundary and random
// messages checked against an in-bench prediction of each result word.
// Depends on jpoe_pkg, the channel interfaces in jpoe_if.sv and the block's top level.
`timescale 1ns / 1ps

module tb_json_payload_object_extractor;
  import jpoe_pkg::*;

  // Generous limit for the whole run.
  localparam int unsigned CycleLimit = 2_000_000;
  // Settling after a drain, past the result register and its one-word skid.
  localparam int SettleCycles = 8;
  localparam string KeyText = "\"payload\":";

  logic clk = 1'b0;
  logic rst_n;

  jpoe_in_if  in_ch ();
  jpoe_out_if out_ch ();
  jpoe_cfg_if cfg_ch ();

  json_payload_object_extractor i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted extractor state and the words it still owes us
  // ---------------------------------------------------------------------------
  phase_t                scan;
  logic [3:0]            key_pos;
  logic [15:0]           depth;
  logic [CountWidth-1:0] count;
  logic [15:0]           buf_size;

  result_t     due_words[$];
  int unsigned mismatches = 0;
  int unsigned live_chars;     // characters the block actually acted on
  int unsigned cycles = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  logic [7:0] msg_chars[$];    // message being assembled

  function automatic logic [LenWidth-1:0] length_of(input logic [CountWidth-1:0] n);
    if (CountWidth > LenWidth && n > CountWidth'(LenMax)) begin
      return LenMax;
    end
    return LenWidth'(n);
  endfunction

  function automatic void restart_scan();
    scan    = PhSearch;
    key_pos = '0;
    depth   = '0;
    count   = '0;
  endfunction

  // Advance the predicted state by one accepted character and queue the
  // result word it causes, if any.
  function automatic void predict_extraction(input logic [7:0] c, input logic last);
    int         j;
    logic       bv;
    logic       sv;
    status_t    st;
    logic [15:0] plen;
    result_t    w;
    bv   = 1'b0;
    sv   = 1'b0;
    st   = StOk;
    plen = '0;
    if (scan != PhDone) live_chars++;
    case (scan)
      PhSeek: begin
        if (c == BraceOpen) begin
          scan  = PhObject;
          depth = 16'd1;
          count = CountWidth'(1);
          bv    = 1'b1;
        end
      end
      PhObject: begin
        bv = 1'b1;
        if (count != CountMax) count = count + 1'b1;
        if (c == BraceOpen) begin
          if (depth != DepthMax) depth = depth + 1'b1;
        end else if (c == BraceClose) begin
          if (depth != 0) depth = depth - 1'b1;
          if (depth == 0) begin
            sv   = 1'b1;
            plen = length_of(count);
            // full-scale count never fits, whatever the buffer says
            if (32'(count) >= 32'(buf_size) || count == CountMax) st = StTooLarge;
            else st = StOk;
            scan = PhDone;
          end
        end
      end
      PhDone: ;
      default: begin
        // key matcher; on a miss after the closing quote, that quote may
        // itself open a new match
        j = (key_pos < KeyLen) ? int'(key_pos) : 0;
        while (j > 0 && c != KeyText[j]) j = (j == KeyLen - 1) ? 1 : 0;
        if (c == KeyText[j]) j++;
        if (j >= KeyLen) begin
          scan = PhSeek;
          j    = 0;
        end
        key_pos = 4'(j);
      end
    endcase
    if (last) begin
      if (!sv && scan != PhDone) begin
        sv = 1'b1;
        case (scan)
          PhSearch: st = StNoKey;
          PhSeek:   st = StNoBrace;
          default: begin
            st   = StNoEnd;
            plen = length_of(count);
          end
        endcase
      end
      restart_scan();
    end
    if (bv || sv) begin
      w.out_byte       = bv ? c : 8'h00;
      w.byte_valid     = bv;
      w.status_valid   = sv;
      w.status         = sv ? st : StOk;
      w.payload_length = sv ? plen : '0;
      due_words.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every accepted word against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endfunction

  result_t want;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_words.size() == 0) begin
        mismatches++;
        $error("unexpected result word: out_byte %0d status_valid %0b",
               out_ch.out_byte, out_ch.status_valid);
      end else begin
        want = due_words.pop_front();
        check_field("out_byte", 16'(want.out_byte), 16'(out_ch.out_byte));
        check_field("byte_valid", 16'(want.byte_valid), 16'(out_ch.byte_valid));
        check_field("status_valid", 16'(want.status_valid), 16'(out_ch.status_valid));
        check_field("status", 16'(want.status), 16'(out_ch.status));
        check_field("payload_length", want.payload_length, out_ch.payload_length);
      end
    end
  end

  // Receiver stalls at random, at the rate the current phase asks.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("json_payload_object_extractor regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one character word; the sender may idle first. Valid stays high
  // across back-to-back words.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= c;
    in_ch.msg_last <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_extraction(c, last);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_chars.push_back(s[i]);
  endfunction

  function automatic void add_filler(input int n, input logic [7:0] c);
    repeat (n) msg_chars.push_back(c);
  endfunction

  // Send the assembled message, msg_last on its final character.
  task automatic send_message();
    int n;
    n = msg_chars.size();
    for (int i = 0; i < n; i++) send_char(msg_chars[i], i == n - 1);
    msg_chars.delete();
  endtask

  // Lower valid and let every owed word come out, then the pipeline empty.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // buffer_size is only written while the block is idle.
  task automatic write_buffer_size(input logic [15:0] size);
    drain();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.buffer_size <= size;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    buf_size = size;
  endtask

  function automatic void set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset value 1024: a 1024-word payload does not fit.
  task automatic test_reset_buffer_size();
    add_text({KeyText, "{"});
    add_filler(1022, "y");
    add_text("}");
    send_message();
  endtask

  task automatic test_special_cases();
    add_text("no key here");                       // key not found
    send_message();
    add_text(KeyText);                             // key completes on the last char
    send_message();
    add_text({KeyText, " }12"});                   // brace not found, '}' ignored
    send_message();
    add_text({KeyText, "{"});                      // opening brace on the last char
    send_message();
    add_text({"xx", KeyText, " {a}"});             // closing brace on the last char
    send_message();
    add_text({KeyText, "{ab"});                    // end not found, partial count
    send_message();
    // NUL and all-ones characters are ordinary
    msg_chars.push_back(8'h00);
    add_text({KeyText, "{"});
    msg_chars.push_back(8'h00);
    msg_chars.push_back(8'hFF);
    add_text("}");
    msg_chars.push_back(8'h00);
    send_message();
    // matcher fallback: a stray quote after a near match starts a new one
    add_text({"\"payload\"", KeyText, "{}"});
    send_message();
    add_text({"\"\"payloa\"", KeyText, "{1}z"});
    send_message();
    // quotes are not honored; extra objects and keys after the status are ignored
    add_text({KeyText, "{\"a\":{\"b\":\"}\"}}}{q}", KeyText, "{r}"});
    send_message();
  endtask

  task automatic test_buffer_extremes();
    write_buffer_size(16'd0);                      // nothing fits
    add_text({KeyText, "{}"});
    send_message();
    write_buffer_size(16'd1);
    add_text({KeyText, "{}tail"});
    send_message();
    write_buffer_size(16'd3);                      // boundary: 2 fits, 3 does not
    add_text({KeyText, "{}"});
    send_message();
    add_text({KeyText, "{a}"});
    send_message();
    add_text({KeyText, "{abc"});                   // end not found past the buffer
    send_message();
    write_buffer_size(16'hFFFF);
    add_text({KeyText, "{{}}"});
    send_message();
  endtask

  // Mostly well-formed messages with random content, plus noise and
  // truncated ones.
  task automatic build_random_message();
    int         kind;
    int         n;
    int         d;
    int         lim;
    int         r;
    logic [7:0] c;
    kind = $urandom_range(0, 19);
    n = $urandom_range(0, 5);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       add_text("\"pay");
        1:       add_text("\"payload\"");
        2:       msg_chars.push_back(8'($urandom_range(0, 255)));
        default: msg_chars.push_back(8'($urandom_range(32, 126)));
      endcase
    end
    if (kind == 0) begin
      msg_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_text(KeyText);
      n = $urandom_range(0, 3);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        msg_chars.push_back((c == BraceOpen) ? 8'h20 : c);
      end
      if (kind != 1) begin
        lim = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
        msg_chars.push_back(BraceOpen);
        d = 1;
        n = 0;
        while (d > 0) begin
          r = $urandom_range(0, 99);
          if (n >= lim || (r < 12 && d > 1)) begin
            msg_chars.push_back(BraceClose);
            d--;
          end else if (r < 24 && d < 6) begin
            msg_chars.push_back(BraceOpen);
            d++;
          end else begin
            c = 8'($urandom_range(0, 255));
            msg_chars.push_back((c == BraceOpen || c == BraceClose) ? 8'h22 : c);
          end
          n++;
        end
      end
      n = $urandom_range(0, 4);
      repeat (n) msg_chars.push_back(8'($urandom_range(0, 255)));
    end
    // broken message: cut anywhere
    if ($urandom_range(0, 7) == 0 && msg_chars.size() > 1) begin
      msg_chars = msg_chars[0:$urandom_range(0, msg_chars.size() - 2)];
    end
  endtask

  task automatic test_random_traffic(input int unsigned items);
    int unsigned stop_at;
    int unsigned next_cfg;
    stop_at  = live_chars + items;
    next_cfg = live_chars + 150;
    while (live_chars < stop_at) begin
      if (live_chars >= next_cfg) begin
        case ($urandom_range(0, 5))
          0:       write_buffer_size(16'd0);
          1:       write_buffer_size(16'd1);
          2:       write_buffer_size(16'hFFFF);
          3:       write_buffer_size(16'($urandom_range(0, 65535)));
          default: write_buffer_size(16'($urandom_range(2, 40)));
        endcase
        next_cfg = live_chars + 150;
      end
      build_random_message();
      send_message();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.msg_last     = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.buffer_size = 16'd0;
    live_chars         = 0;
    buf_size           = BufferSizeReset;
    restart_scan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver stalls hard
    set_idling(10, 82);
    test_reset_buffer_size();
    test_special_cases();
    test_buffer_extremes();
    test_random_traffic(200);

    // the other way round
    set_idling(82, 10);
    test_random_traffic(200);

    // full rate
    set_idling(0, 0);
    test_random_traffic(200);

    drain();
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("json_payload_object_extractor regression: pass");
    end else begin
      $display("json_payload_object_extractor regression: fail");
    end
    $finish;
  end

endmodule
